// ===== sv/assert_macros.svh =====
// Assertion macros shared by the seat allocator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define NFSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define NFSA_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/nfsa_pkg.sv =====
// Types and constants of the next-free-seat allocator.
// Depends on nothing; used by nfsa_scan and next_free_slot_allocator_unit.
package nfsa_pkg;

    localparam int SEAT_W  = 11;
    localparam int WIN_W   = 10;
    localparam int ID_W    = 16;
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEAT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 1'b1;

    localparam logic [SEAT_W-1:0] SEAT_COUNT_RST = 11'd1024;
    localparam logic [WIN_W-1:0]  WINDOW_RST     = 10'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_RESULT
    } nfsa_state_t;

    // Control for one word scan
    typedef struct packed {
        logic             first;
        logic             last;
        logic [BIT_W-1:0] lo_bit;
        logic [BIT_W-1:0] hi_bit;
    } scan_ctl_t;

    // Outcome of one word scan
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] idx;
    } scan_res_t;

endpackage

// ===== sv/nfsa_scan.sv =====
// Word scan unit: masks one 64-bit map word to the search range and
// finds the lowest free seat in it. Depends on nfsa_pkg.
module nfsa_scan (
    input  logic [nfsa_pkg::WORD_W-1:0] taken_word,
    input  nfsa_pkg::scan_ctl_t         ctl,
    output nfsa_pkg::scan_res_t         res
);

    logic [nfsa_pkg::WORD_W-1:0] mask_lo;
    logic [nfsa_pkg::WORD_W-1:0] mask_hi;
    logic [nfsa_pkg::WORD_W-1:0] free_bits;

    // Limit to bits at or above the bound and at or below the limit
    always_comb begin
        mask_lo   = ctl.first ? ({nfsa_pkg::WORD_W{1'b1}} << ctl.lo_bit)
                              : {nfsa_pkg::WORD_W{1'b1}};
        mask_hi   = ctl.last  ? ({nfsa_pkg::WORD_W{1'b1}} >> (~ctl.hi_bit))
                              : {nfsa_pkg::WORD_W{1'b1}};
        free_bits = ~taken_word & mask_lo & mask_hi;
    end

    // Find the lowest free bit
    always_comb begin
        res.hit = |free_bits;
        res.idx = '0;
        for (int i = nfsa_pkg::WORD_W - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                res.idx = nfsa_pkg::BIT_W'(i);
            end
        end
    end

endmodule

// ===== sv/next_free_slot_allocator_unit.sv =====
// Next-free-seat allocator: top level with sequencer, taken-seat map memory
// and output register. Depends on nfsa_pkg, nfsa_scan and assert_macros.svh.
//
// Usage: a request word (s_lower_bound, s_request_id) enters on the s_ channel
// under valid/ready; exactly one result word (m_granted, m_assigned_seat,
// m_echoed_id) leaves on the m_ channel in request order. Seats 1..MAX_SEATS
// live in a memory of 64-bit words, one bit per seat.
// Sequence: the request is accepted, then each map word scanned is read and
// then checked and marked, then the output register is loaded once it is free.
// A request touches at most min(ceil((window_extent + 1) / 64) + 1, MAP_WORDS)
// words. Out-of-range bounds skip the scan. The single memory read port and
// the shared word scan unit mean that one request is in work at a time.
// Reset: seat_count returns to 1024, window_extent to 0, and a clearing pass
// writes every map word to zero, one word a cycle; s_ready stays low during
// it. Configuration writes via cfg_wr_en/cfg_index/cfg_wdata are taken at any
// time but belong in idle.
// Stall: a finished result waits in the output register while m_ready is low;
// the next request is accepted and scanned meanwhile, and its result is held
// back until the output register frees.
`include "assert_macros.svh"

module next_free_slot_allocator_unit #(
    parameter int MAX_SEATS = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [nfsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nfsa_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [nfsa_pkg::SEAT_W-1:0]     s_lower_bound,
    input  logic [nfsa_pkg::ID_W-1:0]       s_request_id,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_granted,
    output logic [nfsa_pkg::SEAT_W-1:0]     m_assigned_seat,
    output logic [nfsa_pkg::ID_W-1:0]       m_echoed_id
);

    localparam int MAP_WORDS = (MAX_SEATS + nfsa_pkg::WORD_W - 1) / nfsa_pkg::WORD_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);
    localparam logic [nfsa_pkg::SEAT_W-1:0] MAX_SEAT_CAP = nfsa_pkg::SEAT_W'(MAX_SEATS);

    // Configuration registers
    logic [nfsa_pkg::SEAT_W-1:0] seat_count_reg;
    logic [nfsa_pkg::WIN_W-1:0]  window_reg;

    // Sequencer and search registers
    nfsa_pkg::nfsa_state_t state_reg, state_next;
    logic [AW-1:0]               clr_addr_reg;
    logic [AW-1:0]               word_reg;
    logic [AW-1:0]               last_word_reg;
    logic                        first_reg;
    logic [nfsa_pkg::BIT_W-1:0]  lo_bit_reg;
    logic [nfsa_pkg::BIT_W-1:0]  hi_bit_reg;
    logic [nfsa_pkg::ID_W-1:0]   id_reg;
    logic                        found_reg;
    logic [nfsa_pkg::SEAT_W-1:0] seat_reg;

    // Output register
    logic                        m_valid_reg;
    logic                        m_granted_reg;
    logic [nfsa_pkg::SEAT_W-1:0] m_seat_reg;
    logic [nfsa_pkg::ID_W-1:0]   m_id_reg;

    // Map memory
    logic [nfsa_pkg::WORD_W-1:0] map_mem [MAP_WORDS];
    logic [nfsa_pkg::WORD_W-1:0] rd_data_reg;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [nfsa_pkg::WORD_W-1:0] mem_wdata;
    logic                        mem_re;

    // Control decoded from state
    logic                        accept;
    logic                        out_free;
    logic                        load_out;

    // Request range
    logic [nfsa_pkg::SEAT_W-1:0] count_eff;
    logic                        bound_ok;
    logic [nfsa_pkg::SEAT_W:0]   limit_sum;
    logic [nfsa_pkg::SEAT_W-1:0] limit;
    logic [nfsa_pkg::SEAT_W-1:0] lo_pos;
    logic [nfsa_pkg::SEAT_W-1:0] hi_pos;
    logic [nfsa_pkg::SEAT_W-1:0] lo_word_full;
    logic [nfsa_pkg::SEAT_W-1:0] hi_word_full;

    // Scan unit
    nfsa_pkg::scan_ctl_t         scan_ctl;
    nfsa_pkg::scan_res_t         scan_res;
    logic                        scan_last;
    logic [AW+nfsa_pkg::BIT_W-1:0] hit_pos;
    logic [nfsa_pkg::SEAT_W-1:0] hit_seat;

    // Decode the request range
    always_comb begin
        count_eff    = (32'(seat_count_reg) > MAX_SEATS) ? MAX_SEAT_CAP : seat_count_reg;
        bound_ok     = (s_lower_bound != '0) && (s_lower_bound <= count_eff);
        limit_sum    = {1'b0, s_lower_bound} + (nfsa_pkg::SEAT_W + 1)'(window_reg);
        limit        = (limit_sum > {1'b0, count_eff}) ? count_eff
                                                       : limit_sum[nfsa_pkg::SEAT_W-1:0];
        lo_pos       = s_lower_bound - 1'b1;
        hi_pos       = limit - 1'b1;
        lo_word_full = lo_pos >> nfsa_pkg::BIT_W;
        hi_word_full = hi_pos >> nfsa_pkg::BIT_W;
    end

    // Drive the scan unit from the current word
    assign scan_last = (word_reg == last_word_reg);
    always_comb begin
        scan_ctl.first  = first_reg;
        scan_ctl.last   = scan_last;
        scan_ctl.lo_bit = lo_bit_reg;
        scan_ctl.hi_bit = hi_bit_reg;
    end

    nfsa_scan u_scan (
        .taken_word (rd_data_reg),
        .ctl        (scan_ctl),
        .res        (scan_res)
    );

    assign hit_pos  = {word_reg, scan_res.idx};
    assign hit_seat = nfsa_pkg::SEAT_W'(hit_pos) + 1'b1;

    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            nfsa_pkg::ST_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = nfsa_pkg::ST_IDLE;
                end
            end
            nfsa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = bound_ok ? nfsa_pkg::ST_FETCH : nfsa_pkg::ST_RESULT;
                end
            end
            nfsa_pkg::ST_FETCH: begin
                state_next = nfsa_pkg::ST_SCAN;
            end
            nfsa_pkg::ST_SCAN: begin
                if (scan_res.hit || scan_last) begin
                    state_next = nfsa_pkg::ST_RESULT;
                end else begin
                    state_next = nfsa_pkg::ST_FETCH;
                end
            end
            nfsa_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = nfsa_pkg::ST_IDLE;
                end
            end
            default: state_next = nfsa_pkg::ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = word_reg;
        mem_wdata = rd_data_reg | ({{(nfsa_pkg::WORD_W-1){1'b0}}, 1'b1} << scan_res.idx);
        mem_re    = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            nfsa_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            nfsa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            nfsa_pkg::ST_FETCH: begin
                mem_re = 1'b1;
            end
            nfsa_pkg::ST_SCAN: begin
                mem_we = scan_res.hit;
            end
            nfsa_pkg::ST_RESULT: begin
                load_out = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    // Map memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= map_mem[word_reg];
        end
    end

    // Configuration registers and sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seat_count_reg <= nfsa_pkg::SEAT_COUNT_RST;
            window_reg     <= nfsa_pkg::WINDOW_RST;
            state_reg      <= nfsa_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    nfsa_pkg::CFG_SEAT_COUNT: seat_count_reg <= cfg_wdata;
                    nfsa_pkg::CFG_WINDOW:     window_reg <= cfg_wdata[nfsa_pkg::WIN_W-1:0];
                    default:                  seat_count_reg <= seat_count_reg;
                endcase
            end
            state_reg <= state_next;
            if (state_reg == nfsa_pkg::ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            // Hold the result until taken, load a new one when free
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Search datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            id_reg        <= s_request_id;
            word_reg      <= AW'(lo_word_full);
            last_word_reg <= AW'(hi_word_full);
            lo_bit_reg    <= lo_pos[nfsa_pkg::BIT_W-1:0];
            hi_bit_reg    <= hi_pos[nfsa_pkg::BIT_W-1:0];
            first_reg     <= 1'b1;
            found_reg     <= 1'b0;
            seat_reg      <= '0;
        end else if (state_reg == nfsa_pkg::ST_SCAN) begin
            if (scan_res.hit) begin
                found_reg <= 1'b1;
                seat_reg  <= hit_seat;
            end else if (!scan_last) begin
                // Advance to the next map word
                word_reg  <= word_reg + 1'b1;
                first_reg <= 1'b0;
            end
        end
        if (load_out) begin
            m_granted_reg <= found_reg;
            m_seat_reg    <= seat_reg;
            m_id_reg      <= id_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_granted       = m_granted_reg;
    assign m_assigned_seat = m_seat_reg;
    assign m_echoed_id     = m_id_reg;

    // Checks on the sequencer and the result
    `NFSA_ASSERT_NR(a_reset_clears, aclk, !aresetn |=> state_reg == nfsa_pkg::ST_CLEAR, "reset did not start the clearing pass")
    `NFSA_ASSERT(a_accept_next, aclk, aresetn, accept |=> (state_reg == nfsa_pkg::ST_FETCH || state_reg == nfsa_pkg::ST_RESULT), "accepted word did not start a search")
    `NFSA_ASSERT(a_word_range, aclk, aresetn, state_reg == nfsa_pkg::ST_FETCH |-> word_reg <= last_word_reg, "scan ran past the last map word")
    `NFSA_ASSERT(a_grant_seat, aclk, aresetn, m_valid_reg |-> (m_granted_reg == (m_seat_reg != '0)), "grant flag and seat number disagree")

endmodule

// ===== test/next_free_slot_allocator_unit_tb.sv =====
// Self-checking testbench for next_free_slot_allocator_unit: a clocked driver and
// monitor around a seat-map predictor, with register phases between request bursts.
// Depends on nfsa_pkg and next_free_slot_allocator_unit.
module next_free_slot_allocator_unit_tb;

    localparam int TB_SEATS    = 1024;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [nfsa_pkg::SEAT_W-1:0] bound;
        logic [nfsa_pkg::ID_W-1:0]   id;
    } seat_req_t;

    typedef struct packed {
        logic                        granted;
        logic [nfsa_pkg::SEAT_W-1:0] seat;
        logic [nfsa_pkg::ID_W-1:0]   id;
    } seat_grant_t;

    logic                           aclk            = 1'b0;
    logic                           aresetn         = 1'b0;
    logic                           cfg_wr_en       = 1'b0;
    logic [nfsa_pkg::CFG_IDX_W-1:0] cfg_index       = nfsa_pkg::CFG_SEAT_COUNT;
    logic [nfsa_pkg::CFG_W-1:0]     cfg_wdata       = '0;
    logic                           s_valid         = 1'b0;
    logic                           s_ready;
    logic [nfsa_pkg::SEAT_W-1:0]    s_lower_bound   = '0;
    logic [nfsa_pkg::ID_W-1:0]      s_request_id    = '0;
    logic                           m_valid;
    logic                           m_ready         = 1'b0;
    logic                           m_granted;
    logic [nfsa_pkg::SEAT_W-1:0]    m_assigned_seat;
    logic [nfsa_pkg::ID_W-1:0]      m_echoed_id;

    // Predictor state: taken map and register copies
    bit                             taken_seats [1:TB_SEATS];
    logic [nfsa_pkg::CFG_W-1:0]     seat_count_q  = nfsa_pkg::SEAT_COUNT_RST;
    logic [nfsa_pkg::WIN_W-1:0]     window_q      = nfsa_pkg::WINDOW_RST;

    seat_req_t            request_backlog [$];
    seat_grant_t          grants_due [$];
    seat_req_t            next_req;
    seat_grant_t          want;
    int                   mismatch_count = 0;
    int                   tx_idle_pct    = 0;
    int                   rx_idle_pct    = 0;
    int                   tx_gap         = 0;
    int                   rx_stall       = 0;
    bit                   hold_off       = 1'b0;
    int                   cycle_count    = 0;

    next_free_slot_allocator_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_lower_bound   (s_lower_bound),
        .s_request_id    (s_request_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted       (m_granted),
        .m_assigned_seat (m_assigned_seat),
        .m_echoed_id     (m_echoed_id)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Find the lowest free seat in [bound, min(count, bound + window)] and claim it
    function automatic seat_grant_t grant_seat(input logic [nfsa_pkg::SEAT_W-1:0] bound,
                                               input logic [nfsa_pkg::ID_W-1:0] id);
        int unsigned count;
        int unsigned top;
        int unsigned s;
        int unsigned found;
        seat_grant_t g;
        count = seat_count_q;
        found = 0;
        if (count > TB_SEATS)
            count = TB_SEATS;
        if (bound >= 1 && bound <= count) begin
            top = bound + window_q;
            if (top > count)
                top = count;
            for (s = bound; s <= top; s++) begin
                if (!taken_seats[s]) begin
                    found = s;
                    break;
                end
            end
        end
        if (found != 0)
            taken_seats[found] = 1'b1;
        g.granted = (found != 0);
        g.seat    = found[nfsa_pkg::SEAT_W-1:0];
        g.id      = id;
        return g;
    endfunction

    // Zero with probability (100 - pct) percent; else usually a short gap, rarely a long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Driver: predict on accept, then load the next word from the backlog
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                grants_due = {grants_due, grant_seat(s_lower_bound, s_request_id)};
            if (!s_valid || s_ready) begin
                if (hold_off && grants_due.size() == 0)
                    hold_off = 1'b0;
                if (tx_gap != 0 || hold_off || request_backlog.size() == 0) begin
                    if (tx_gap != 0)
                        tx_gap--;
                    s_valid <= 1'b0;
                end else begin
                    next_req = request_backlog.pop_front();
                    s_valid       <= 1'b1;
                    s_lower_bound <= next_req.bound;
                    s_request_id  <= next_req.id;
                    tx_gap   = pick_gap(tx_idle_pct);
                    hold_off = ($urandom_range(0, 199) == 0);
                end
            end
        end
    end

    // Monitor: check each result word against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (grants_due.size() == 0) begin
                    $display("%0t: result with none expected: granted %0d seat %0d id %0h",
                             $time, m_granted, m_assigned_seat, m_echoed_id);
                    mismatch_count++;
                end else begin
                    want = grants_due.pop_front();
                    if (m_granted !== want.granted) begin
                        $display("%0t: granted expected %0d actual %0d",
                                 $time, want.granted, m_granted);
                        mismatch_count++;
                    end
                    if (m_assigned_seat !== want.seat) begin
                        $display("%0t: assigned_seat expected %0d actual %0d",
                                 $time, want.seat, m_assigned_seat);
                        mismatch_count++;
                    end
                    if (m_echoed_id !== want.id) begin
                        $display("%0t: echoed_id expected %0h actual %0h",
                                 $time, want.id, m_echoed_id);
                        mismatch_count++;
                    end
                end
            end
            if (rx_stall != 0) begin
                m_ready <= 1'b0;
                rx_stall--;
            end else begin
                m_ready <= 1'b1;
                rx_stall = pick_gap(rx_idle_pct);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("next_free_slot_allocator_unit_tb failed");
            $finish;
        end
    end

    task automatic push_req(input int bound, input int id);
        seat_req_t r;
        r.bound = bound[nfsa_pkg::SEAT_W-1:0];
        r.id    = id[nfsa_pkg::ID_W-1:0];
        request_backlog = {request_backlog, r};
    endtask

    // Drive one register write; the enable is dropped by end_writes
    task automatic write_reg(input logic [nfsa_pkg::CFG_IDX_W-1:0] idx, input int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[nfsa_pkg::CFG_W-1:0];
        if (idx == nfsa_pkg::CFG_SEAT_COUNT)
            seat_count_q = val[nfsa_pkg::CFG_W-1:0];
        else
            window_q = val[nfsa_pkg::WIN_W-1:0];
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every word is sent and every result is back
    task automatic wait_idle();
        do
            @(posedge aclk);
        while (request_backlog.size() != 0 || s_valid || grants_due.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        int lo;
        int hi;
        int b;
        int n;
        int p;
        int i;
        int cnt;
        int win;

        for (i = 1; i <= TB_SEATS; i++)
            taken_seats[i] = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Default registers: zero bound, taken seat, bounds above the count
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        push_req(0, 16'h0000);
        push_req(1, 16'hFFFF);
        push_req(1, 16'hAAAA);
        push_req(1024, 16'h5555);
        push_req(1025, 1);
        push_req(2047, 2);
        push_req(1023, 3);
        push_req(1024, 4);
        push_req(512, 16'h8001);
        wait_idle();

        // Widest window, written with the unused top bit set
        write_reg(nfsa_pkg::CFG_WINDOW, 11'h7FF);
        end_writes();
        push_req(1, 5);
        push_req(1000, 6);
        push_req(1023, 7);
        wait_idle();

        // Zero seat count rejects everything
        write_reg(nfsa_pkg::CFG_SEAT_COUNT, 0);
        end_writes();
        push_req(1, 8);
        push_req(0, 9);
        wait_idle();

        // Count above the map saturates
        write_reg(nfsa_pkg::CFG_SEAT_COUNT, 2047);
        write_reg(nfsa_pkg::CFG_WINDOW, 0);
        end_writes();
        push_req(1024, 10);
        push_req(1025, 11);
        wait_idle();

        // Count lowered below seats already taken
        write_reg(nfsa_pkg::CFG_SEAT_COUNT, 2);
        write_reg(nfsa_pkg::CFG_WINDOW, 5);
        end_writes();
        push_req(1, 12);
        push_req(2, 13);
        push_req(3, 14);
        wait_idle();

        write_reg(nfsa_pkg::CFG_SEAT_COUNT, 1);
        write_reg(nfsa_pkg::CFG_WINDOW, 0);
        end_writes();
        push_req(1, 15);
        wait_idle();

        // Random phases: each works a fresh region of the map with rising bounds
        for (p = 0; p < 12; p++) begin
            lo = 1 + p * 85;
            hi = lo + 84;
            case (p % 4)
                0: cnt = hi;
                1: cnt = 1024;
                2: cnt = 2047;
                default: cnt = hi + $urandom_range(0, 3);
            endcase
            case (p % 5)
                0: win = 0;
                1: win = $urandom_range(1, 8);
                2: win = $urandom_range(9, 80);
                3: win = 1023;
                default: win = $urandom_range(0, 1023);
            endcase
            case (p % 3)
                0: tx_idle_pct = 0;
                1: tx_idle_pct = 25;
                default: tx_idle_pct = 60;
            endcase
            case ((p + 1) % 3)
                0: rx_idle_pct = 0;
                1: rx_idle_pct = 25;
                default: rx_idle_pct = 60;
            endcase
            write_reg(nfsa_pkg::CFG_SEAT_COUNT, cnt);
            write_reg(nfsa_pkg::CFG_WINDOW, win);
            end_writes();

            b = lo;
            n = $urandom_range(105, 120);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 99) < 85) begin
                    push_req(b, $urandom_range(0, 65535));
                    if ($urandom_range(0, 3) != 0 && b < hi)
                        b++;
                end else begin
                    case ($urandom_range(0, 3))
                        0: push_req(0, $urandom_range(0, 65535));
                        1: push_req($urandom_range(hi + 1, 2047), $urandom_range(0, 65535));
                        2: push_req($urandom_range(lo, hi), $urandom_range(0, 65535));
                        default: push_req($urandom_range(0, 2047), $urandom_range(0, 65535));
                    endcase
                end
            end
            wait_idle();
        end

        repeat (50) @(posedge aclk);
        if (grants_due.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("next_free_slot_allocator_unit_tb passed");
        else
            $display("next_free_slot_allocator_unit_tb failed");
        $finish;
    end

endmodule
